// ===== hw/rtl/dnsenc_pkg.sv =====
// ----------------------------------------------------------------------------
// dnsenc_pkg
// Shared constants and types of the DNS name wire-format encoder.
// ----------------------------------------------------------------------------
package dnsenc_pkg;

    localparam int WIRE_BYTES = 256;
    localparam int MAX_LABEL  = 63;
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 7;    // label length, holds MAX_LABEL + 1
    localparam int LENGTH_W   = 9;    // reported wire length
    localparam int OFF_W      = $clog2(WIRE_BYTES + 1);
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int TDATA_W    = 32;
    localparam int TUSER_W    = 3;

    localparam logic [BYTE_W-1:0] SEPARATOR = 8'h2E;

    typedef enum logic [1:0] {
        JOB_WRITE,
        JOB_END_OK,
        JOB_END_FAIL
    } job_kind_t;

    // One job per input transaction that yields results.
    // END_OK: optional length byte at off_a, then terminator at off_b.
    typedef struct packed {
        job_kind_t          kind;
        logic [BYTE_W-1:0]  data;
        logic [OFF_W-1:0]   off_a;
        logic               has_len;
        logic [OFF_W-1:0]   off_b;
    } job_t;

endpackage

// ===== hw/rtl/dnsenc_front.sv =====
// ----------------------------------------------------------------------------
// dnsenc_front
// Takes characters and end marks, tracks label state, queues output jobs.
// ----------------------------------------------------------------------------
module dnsenc_front import dnsenc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,
    input  logic              s_tlast,
    input  logic              q_full,
    output logic              q_push,
    output job_t              q_job
);

    logic [OFF_W-1:0] start_reg, start_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             failed_reg, failed_next;

    logic             accept;
    logic [LEN_W-1:0] len_inc;
    logic [OFF_W:0]   reach;
    logic [OFF_W-1:0] after_label;
    logic             too_long;

    assign s_tready    = !q_full;
    assign accept      = s_tvalid && !q_full;
    assign len_inc     = len_reg + LEN_W'(1);
    assign reach       = {1'b0, start_reg} + (OFF_W+1)'(len_inc) + (OFF_W+1)'(1);
    assign after_label = start_reg + OFF_W'(len_reg) + OFF_W'(1);
    assign too_long    = (len_inc > LEN_W'(MAX_LABEL)) ||
                         (reach >= (OFF_W+1)'(WIRE_BYTES));

    always_comb begin
        start_next  = start_reg;
        len_next    = len_reg;
        failed_next = failed_reg;
        q_push      = 1'b0;
        q_job.kind    = JOB_WRITE;
        q_job.data    = s_tdata;
        q_job.off_a   = after_label;
        q_job.has_len = 1'b0;
        q_job.off_b   = start_reg;
        if (accept) begin
            if (s_tlast) begin
                q_push        = 1'b1;
                q_job.kind    = failed_reg ? JOB_END_FAIL : JOB_END_OK;
                q_job.data    = BYTE_W'(len_reg);
                q_job.off_a   = start_reg;
                q_job.has_len = (len_reg != '0);
                q_job.off_b   = (len_reg != '0) ? after_label : start_reg;
                start_next    = '0;
                len_next      = '0;
                failed_next   = 1'b0;
            end else if (!failed_reg) begin
                if (s_tdata == SEPARATOR) begin
                    if (len_reg == '0) begin
                        failed_next = 1'b1;   // leading or double dot
                    end else begin
                        q_push      = 1'b1;
                        q_job.data  = BYTE_W'(len_reg);
                        q_job.off_a = start_reg;
                        start_next  = after_label;
                        len_next    = '0;
                    end
                end else if (too_long) begin
                    failed_next = 1'b1;
                end else begin
                    q_push   = 1'b1;
                    len_next = len_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg  <= '0;
            len_reg    <= '0;
            failed_reg <= 1'b0;
        end else begin
            start_reg  <= start_next;
            len_reg    <= len_next;
            failed_reg <= failed_next;
        end
    end

endmodule

// ===== hw/rtl/dnsenc_queue.sv =====
// ----------------------------------------------------------------------------
// dnsenc_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module dnsenc_queue import dnsenc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t head
);

    job_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + (Q_PTR_W+1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (Q_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hw/rtl/dnsenc_back.sv =====
// ----------------------------------------------------------------------------
// dnsenc_back
// Turns queued jobs into result transactions, one per cycle while the output
// is not stalled, into an output register.
// ----------------------------------------------------------------------------
module dnsenc_back import dnsenc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  job_t               q_head,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic [TUSER_W-1:0] m_tuser,
    output logic               m_tlast
);

    logic                out_valid_reg, out_valid_next;
    logic                phase_reg, phase_next;
    logic [7:0]          byte_reg, byte_next;
    logic [7:0]          off_reg, off_next;
    logic [LENGTH_W-1:0] wlen_reg, wlen_next;
    logic                bvalid_reg, bvalid_next;
    logic                done_reg, done_next;
    logic                ok_reg, ok_next;
    logic                last_reg, last_next;

    logic                load;
    logic                first_beat;
    logic [OFF_W:0]      term_len;

    assign load       = !out_valid_reg || m_tready;
    assign first_beat = (q_head.kind == JOB_END_OK) && q_head.has_len && !phase_reg;
    assign term_len   = {1'b0, q_head.off_b} + (OFF_W+1)'(1);

    always_comb begin
        out_valid_next = out_valid_reg;
        phase_next     = phase_reg;
        byte_next      = byte_reg;
        off_next       = off_reg;
        wlen_next      = wlen_reg;
        bvalid_next    = bvalid_reg;
        done_next      = done_reg;
        ok_next        = ok_reg;
        last_next      = last_reg;
        q_pop          = 1'b0;
        if (load) begin
            out_valid_next = !q_empty;
            if (!q_empty) begin
                q_pop       = !first_beat;
                phase_next  = first_beat;
                byte_next   = '0;
                off_next    = '0;
                wlen_next   = '0;
                bvalid_next = 1'b0;
                done_next   = 1'b0;
                ok_next     = 1'b0;
                last_next   = 1'b1;
                case (q_head.kind)
                    JOB_WRITE: begin
                        byte_next   = q_head.data;
                        off_next    = 8'(q_head.off_a);
                        bvalid_next = 1'b1;
                    end
                    JOB_END_OK: begin
                        bvalid_next = 1'b1;
                        if (first_beat) begin
                            byte_next = q_head.data;
                            off_next  = 8'(q_head.off_a);
                            last_next = 1'b0;
                        end else begin
                            off_next  = 8'(q_head.off_b);
                            wlen_next = LENGTH_W'(term_len);
                            done_next = 1'b1;
                            ok_next   = 1'b1;
                        end
                    end
                    default: begin
                        done_next = 1'b1;   // rejected name
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        off_reg    <= off_next;
        wlen_reg   <= wlen_next;
        bvalid_reg <= bvalid_next;
        done_reg   <= done_next;
        ok_reg     <= ok_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(TDATA_W-16-LENGTH_W)'(0), wlen_reg, off_reg, byte_reg};
    assign m_tuser  = {ok_reg, done_reg, bvalid_reg};
    assign m_tlast  = last_reg;

endmodule

// ===== hw/rtl/dns_name_wire_encoder.sv =====
// ----------------------------------------------------------------------------
// dns_name_wire_encoder
// DNS domain name to wire-format encoder, streamed as offset/byte writes.
// ----------------------------------------------------------------------------
// A name enters one character per transaction, closed by a transaction with
// s_tlast high. Characters and dots are taken one per cycle while the queue
// is not full, and each gives at most one result; the closing transaction
// gives one or two (last length byte, then the terminator with done and the
// total length). The front updates the label state in the cycle a transaction
// is taken and posts a job into a four-entry queue; the back drains one result
// per cycle into the output register while the output is not stalled, so each
// result passes through the queue and then the output register.
// A failed name (empty label, label over 63 bytes, buffer overflow) yields
// nothing more until its end, which reports done with ok low.
// ----------------------------------------------------------------------------
module dns_name_wire_encoder import dnsenc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] ch
    input  logic               s_tlast,   // is_end
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [7:0] wire_byte, [15:8] byte_offset,
                                          // [24:16] wire_length, rest zero
    output logic [TUSER_W-1:0] m_tuser,   // [0] byte_valid, [1] done_res, [2] ok
    output logic               m_tlast    // last_of_step
);

    logic q_full, q_empty, q_push, q_pop;
    job_t q_job, q_head;

    dnsenc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_job)
    );

    dnsenc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    dnsenc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== hw/rtl/dnsenc_checker.sv =====
// ----------------------------------------------------------------------------
// dnsenc_checker
// Port-level checks on the encoder result stream.
// ----------------------------------------------------------------------------
module dnsenc_checker import dnsenc_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic [TUSER_W-1:0] m_tuser,
    input logic               m_tlast
);

    // a stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // done always closes the step
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("done without last");

    // rejection carries no write and no length
    a_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tuser[1] && !m_tuser[2] && (m_tdata == '0))
        else $error("bad rejection transaction");

    // success: terminator is zero and length is its offset plus one
    a_term: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tuser[1] && m_tuser[0] && (m_tdata[7:0] == 8'h00)
            && (m_tdata[23:16] == m_tdata[15:8] + 8'd1))
        else $error("bad terminator transaction");

endmodule

bind dns_name_wire_encoder dnsenc_checker u_checker (.*);
